### rtl/padf_pkg.sv
// padf_pkg: shared types and constants for the packed audio stream deframer
// no dependencies; imported by padf_gather and the core top level

package padf_pkg;

    // link and block geometry
    localparam int BLOCK_BYTES  = 8;
    localparam int UNPACK_BYTES = 7;

    // channel count after reset
    localparam int CNT_RESET = 32;

    // control word tag for a stream header (bits 31:30)
    localparam logic [1:0] HDR_TAG = 2'b01;

    // result kinds
    localparam logic KIND_CTRL   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // framer phase once synced
    typedef enum logic [2:0] {
        PH_CTRL = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } padf_phase_t;

    // block sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_FLUSH = 4'b1000
    } padf_state_t;

    // events from the byte gatherer
    typedef struct packed {
        logic sync;
        logic block;
    } padf_evt_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [31:0] control_word;
        logic [7:0]  channel;
        logic [23:0] sample;
        logic        end_of_frame;
    } padf_res_t;

endpackage

### rtl/padf_gather.sv
// padf_gather: input transfer handling, sync detection and 8x7-bit block gathering
// depends on padf_pkg; the packed block is drained one data byte at a time

module padf_gather (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_byte,
    input  logic                 ready,
    input  logic                 consume,
    output padf_pkg::padf_evt_t  evt,
    output logic [7:0]           data
);
    import padf_pkg::*;

    localparam int BLK_W = BLOCK_BYTES * 7;

    logic             synced_reg;
    logic [2:0]       cnt_reg;
    logic [BLK_W-1:0] blk_reg;
    logic             acc;
    logic             is_sync;
    logic             take;

    // input transfer and byte classification
    assign in_stall = !ready;
    assign acc      = in_valid && ready;
    assign is_sync  = in_byte[7];
    assign take     = acc && (is_sync || synced_reg);

    assign evt.sync  = acc && is_sync;
    assign evt.block = take && !is_sync && (cnt_reg == 3'(BLOCK_BYTES - 1));

    // seven-bit groups stacked low first read as a little-endian byte stream
    assign data = blk_reg[7:0];

    // sync flag and position within block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg <= 1'b0;
            cnt_reg    <= 3'd0;
        end
        else if (take)
        begin
            synced_reg <= 1'b1;
            cnt_reg    <= is_sync ? 3'd1 : cnt_reg + 3'd1;
        end
    end

    // block shift line: fill from the top, drain a byte at a time from the bottom
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            blk_reg <= {in_byte[6:0], blk_reg[BLK_W-1:7]};
        end
        else if (consume)
        begin
            blk_reg <= {8'd0, blk_reg[BLK_W-1:8]};
        end
    end

endmodule

### rtl/padf_store.sv
// padf_store: sample slot memory, one write and one registered read port
// no dependencies; per-slot valid bits make unwritten slots read as zero

module padf_store #(
    parameter int SLOTS = 68,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    output logic [23:0]   rd_data
);

    logic [23:0]      mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [23:0]      rdata_reg;
    logic             rvalid_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // written marks, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : 24'd0;

endmodule

### rtl/packed_audio_stream_deframer_core.sv
// packed_audio_stream_deframer_core: top level, block sequencer and result registers
// depends on padf_pkg, padf_gather and padf_store
//
// Usage:
//   Input channel in_valid/in_stall/in_byte carries one link byte per transfer.
//   A byte with bit 7 set is a sync byte; bytes before the first sync are dropped.
//   Eight 7-bit bytes form a block that unpacks into seven data bytes, consumed
//   in order by the control-word and sample phases.
//   Output channel out_valid/out_stall carries one result per transfer: control
//   words with bit 31 set (kind 0) and finished samples (kind 1).
//   last_of_run marks the final result of the byte that completed a block.
// Timing:
//   Input bytes are taken one per cycle while no block is being processed.
//   After the eighth byte of a block, in_stall stays high while the block is processed:
//   an EXEC step per data byte, a FETCH step before each low-byte pass (slot memory
//   read), and a FLUSH step to release the held last result.
//   A result is held in a pending register until the next result or the end of
//   the block shows whether it is the last; it then moves to the output register.
// Reset and stall:
//   Reset returns to the unsynced state with 32 channels of 16-bit samples and
//   all slots reading zero. While out_stall is high the output register holds,
//   and the sequencer waits once both pending and output registers are full.

module packed_audio_stream_deframer_core #(
    parameter int MAX_CHANNELS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [31:0]        control_word,
    output logic [7:0]         channel,
    output logic signed [23:0] sample,
    output logic               end_of_frame,
    output logic               last_of_run
);
    import padf_pkg::*;

    localparam int CNT_MAX = (MAX_CHANNELS > CNT_RESET) ? MAX_CHANNELS : CNT_RESET;
    localparam int CW      = $clog2(CNT_MAX + 1);
    localparam int SLOTS   = MAX_CHANNELS + 4;
    localparam int AW      = $clog2(SLOTS);

    padf_state_t  state_reg,  state_next;
    padf_phase_t  phase_reg,  phase_next;
    logic [31:0]  accum_reg,  accum_next;
    logic [1:0]   wc_reg,     wc_next;
    logic [CW-1:0] ptr_reg,   ptr_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic         wide_reg,   wide_next;
    logic [2:0]   j_reg,      j_next;
    logic         pend_valid_reg, pend_valid_next;
    padf_res_t    pend_reg,   pend_next;
    logic         out_valid_reg,  out_valid_next;
    padf_res_t    out_reg,    out_next;
    logic         out_last_reg,   out_last_next;

    padf_evt_t    evt;
    logic [7:0]   data;
    logic         ready;
    logic         consume;
    logic         rd_en;
    logic         wr_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [23:0]  wr_data;
    logic [23:0]  rd_data;

    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] low_idx;
    logic [CW-1:0] cur_idx;
    logic [8:0]    idx_ext;
    logic          in_rng;
    logic          eof;
    logic [31:0]   ctrl_word;
    logic [15:0]   hi_word;
    logic [23:0]   hi_smp;
    logic [23:0]   lo_smp;
    logic [8:0]    hdr_cnt;
    logic          hdr_ok;
    logic          has_res;
    padf_res_t     res;
    logic          out_free;
    logic          can_go;

    // byte gathering
    padf_gather u_gather (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .ready    (ready),
        .consume  (consume),
        .evt      (evt),
        .data     (data)
    );

    // sample slot memory
    padf_store #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign ready = (state_reg == ST_IDLE);

    // slot addressing; the low pass targets the slot two apart
    assign ptr_inc = ptr_reg + CW'(1);
    assign low_idx = ptr_reg ^ CW'(2);
    assign cur_idx = (phase_reg == PH_LOW) ? low_idx : ptr_reg;
    assign idx_ext = 9'(cur_idx);
    assign in_rng  = (32'(cur_idx) < SLOTS);
    assign eof     = (ptr_inc >= cnt_reg);

    // word and sample assembly from the current data byte
    assign ctrl_word = {data, accum_reg[31:8]};
    assign hi_word   = {data, accum_reg[15:8]};
    assign hi_smp    = {{8{hi_word[15]}}, hi_word};
    assign lo_smp    = in_rng ? {rd_data[15:0], data} : 24'd0;

    // stream header check
    assign hdr_cnt = {1'b0, ctrl_word[7:0]} + 9'd1;
    assign hdr_ok  = (ctrl_word[31:30] == HDR_TAG) && (ctrl_word[29:9] == 21'd0)
                     && (32'(hdr_cnt) <= MAX_CHANNELS);

    // memory ports
    assign rd_en   = (state_reg == ST_FETCH) && in_rng;
    assign rd_addr = AW'(low_idx);
    assign wr_addr = AW'(cur_idx);
    assign wr_data = (phase_reg == PH_LOW) ? lo_smp : hi_smp;

    assign out_free = !out_valid_reg || !out_stall;

    // result produced by the current data byte
    always_comb
    begin
        has_res = 1'b0;
        res     = '0;
        unique case (phase_reg)
            PH_CTRL:
            begin
                if (wc_reg == 2'd3 && ctrl_word[31])
                begin
                    has_res          = 1'b1;
                    res.kind         = KIND_CTRL;
                    res.control_word = ctrl_word;
                end
            end
            PH_HIGH:
            begin
                if (wc_reg == 2'd1 && !wide_reg)
                begin
                    has_res          = 1'b1;
                    res.kind         = KIND_SAMPLE;
                    res.channel      = idx_ext[7:0];
                    res.sample       = hi_smp;
                    res.end_of_frame = eof;
                end
            end
            PH_LOW:
            begin
                has_res          = 1'b1;
                res.kind         = KIND_SAMPLE;
                res.channel      = idx_ext[7:0];
                res.sample       = lo_smp;
                res.end_of_frame = eof;
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

    assign can_go = !has_res || !pend_valid_reg || out_free;

    // block sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        accum_next      = accum_reg;
        wc_next         = wc_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        wide_next       = wide_reg;
        j_next          = j_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        consume         = 1'b0;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt.sync)
                begin
                    phase_next = PH_CTRL;
                    accum_next = 32'd0;
                    wc_next    = 2'd0;
                    ptr_next   = '0;
                end
                if (evt.block)
                begin
                    j_next     = 3'd0;
                    state_next = (phase_reg == PH_LOW) ? ST_FETCH : ST_EXEC;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (can_go)
                begin
                    consume = 1'b1;
                    j_next  = j_reg + 3'd1;

                    // phase work for one data byte
                    unique case (phase_reg)
                        PH_CTRL:
                        begin
                            accum_next = ctrl_word;
                            wc_next    = wc_reg + 2'd1;
                            if (wc_reg == 2'd3)
                            begin
                                if (hdr_ok)
                                begin
                                    cnt_next  = CW'(hdr_cnt);
                                    wide_next = ctrl_word[8];
                                end
                                accum_next = 32'd0;
                                wc_next    = 2'd0;
                                ptr_next   = '0;
                                phase_next = PH_HIGH;
                            end
                        end
                        PH_HIGH:
                        begin
                            accum_next = {16'd0, hi_word};
                            wc_next    = wc_reg + 2'd1;
                            if (wc_reg == 2'd1)
                            begin
                                wr_en      = in_rng;
                                accum_next = 32'd0;
                                wc_next    = 2'd0;
                                ptr_next   = ptr_inc;
                                if (eof)
                                begin
                                    ptr_next = '0;
                                    if (wide_reg)
                                    begin
                                        phase_next = PH_LOW;
                                    end
                                end
                            end
                        end
                        PH_LOW:
                        begin
                            wr_en    = in_rng;
                            ptr_next = ptr_inc;
                            if (eof)
                            begin
                                ptr_next   = '0;
                                phase_next = PH_HIGH;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_CTRL;
                        end
                    endcase

                    // a new result releases the held one as not last
                    if (has_res)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = res;
                    end

                    if (j_reg == 3'(UNPACK_BYTES - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (phase_next == PH_LOW)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_CTRL;
            accum_reg      <= 32'd0;
            wc_reg         <= 2'd0;
            ptr_reg        <= '0;
            cnt_reg        <= CW'(CNT_RESET);
            wide_reg       <= 1'b0;
            j_reg          <= 3'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            accum_reg      <= accum_next;
            wc_reg         <= wc_next;
            ptr_reg        <= ptr_next;
            cnt_reg        <= cnt_next;
            wide_reg       <= wide_next;
            j_reg          <= j_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // output ports
    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign control_word = out_reg.control_word;
    assign channel      = out_reg.channel;
    assign sample       = out_reg.sample;
    assign end_of_frame = out_reg.end_of_frame;
    assign last_of_run  = out_last_reg;

    // nothing is left pending once the block is done
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("result still pending while taking input");

    // slot reads and writes never share a cycle
    a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("slot memory read and write in the same cycle");

    // sample pointer stays inside the frame
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg < cnt_reg)
        else $error("sample pointer beyond channel count");

    // a completed block starts processing on the next cycle
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        evt.block |=> (state_reg == ST_FETCH || state_reg == ST_EXEC))
        else $error("block completed without processing");

endmodule
